@@ src/org_pkg.sv @@
`timescale 1ns / 1ps

package org_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SESSION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 8'd1;

  typedef enum logic [2:0] {
    ACT_PREPARE  = 3'd0,
    ACT_FAIL     = 3'd1,
    ACT_DISPATCH = 3'd2,
    ACT_UNCERTAIN = 3'd3,
    ACT_CANCEL   = 3'd4,
    ACT_REPORT   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    K_ACK    = 3'd0,
    K_TRADE  = 3'd1,
    K_CANACK = 3'd2,
    K_CANREJ = 3'd3,
    K_REJNEW = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_DUP        = 4'd1,
    ST_STALE      = 4'd2,
    ST_FOREIGN    = 4'd3,
    ST_BADSTATE   = 4'd4,
    ST_INVALID    = 4'd5,
    ST_RISK       = 4'd6,
    ST_ORDERFULL  = 4'd7,
    ST_REPORTFULL = 4'd8,
    ST_CONFLICT   = 4'd9,
    ST_HALTED     = 4'd10
  } status_t;

  typedef enum logic [3:0] {
    PH_PREPARED  = 4'd0,
    PH_PENDNEW   = 4'd1,
    PH_LIVE      = 4'd2,
    PH_PENDCAN   = 4'd3,
    PH_UNKNOWN   = 4'd4,
    PH_FILLED    = 4'd5,
    PH_CANCELED  = 4'd6,
    PH_REJECTED  = 4'd7,
    PH_LOCALFAIL = 4'd8
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OSCAN,
    S_DECIDE,
    S_PMUL,
    S_HSCAN,
    S_RCHK1,
    S_RMUL1,
    S_RMUL2,
    S_RCHK3,
    S_FIN
  } state_t;

  // One order table entry
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] quantity;
    logic [63:0] price;
    logic [63:0] filled;
    logic [63:0] cost;
    logic [63:0] reserved;
    logic [63:0] last_num;
    logic        cancel_flag;
    phase_t      phase;
  } slot_t;

  // One report history entry
  typedef struct packed {
    logic [63:0] order;
    logic [63:0] number;
    logic [2:0]  kind;
    logic [63:0] quantity;
    logic [63:0] cost;
    logic [63:0] session;
  } hist_t;

  // Multiplier handshake
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  function automatic logic is_terminal(phase_t p);
    return (p == PH_FILLED) || (p == PH_CANCELED) || (p == PH_REJECTED) ||
           (p == PH_LOCALFAIL);
  endfunction

  // Phase after a halt: working orders become unknown
  function automatic phase_t halt_phase(phase_t p);
    if (!is_terminal(p) && (p != PH_PREPARED)) return PH_UNKNOWN;
    return p;
  endfunction

  function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
    return (a >= b) ? (a - b) : 64'd0;
  endfunction

endpackage

@@ src/org_mul.sv @@
`timescale 1ns / 1ps

// 64x64 -> 128 multiply from four 32x32 partial products, one per cycle.
// Result is valid in prod while done is high.
module org_mul (
  input  logic              clk,
  input  logic              rst,
  input  org_pkg::mul_req_t req,
  output logic              done,
  output logic [127:0]      prod
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic         busy;
  logic [2:0]   step;
  logic         pp_vld;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [31:0]  a_half;
  logic [31:0]  b_half;

  assign a_half = step[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = step[0] ? b_r[63:32] : b_r[31:0];

  // Step through the partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
      step   <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        step   <= 3'd0;
        pp_vld <= 1'b0;
        a_r    <= req.a;
        b_r    <= req.b;
        prod   <= 128'd0;
      end else if (busy) begin
        if (step < 3'd4) begin
          pp     <= {32'd0, a_half} * {32'd0, b_half};
          pp_sh  <= {1'b0, step[1]} + {1'b0, step[0]};
          step   <= step + 3'd1;
          pp_vld <= 1'b1;
        end else begin
          pp_vld <= 1'b0;
        end
        if (pp_vld) begin
          prod <= prod + ({64'd0, pp} << {pp_sh, 5'd0});
        end
        if (pp_vld && (step == 3'd4)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/order_risk_gate_core.sv @@
`timescale 1ns / 1ps
// Flow: each word runs an order scan before its result; prepare adds a multiply; a report
// may add a history scan, the RCHK1 and RCHK3 checks and up to two multiplies.
// Throughput: one word at a time; the next word can be taken in the cycle after the result
// register frees up, so the scans and the shared multiplier set the rate.
// Reset: synchronous rst clears counts, totals, halt and registers to their reset values.
module order_risk_gate_core #(
  parameter int ORDER_SLOTS   = 4,
  parameter int HISTORY_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [63:0] order_key,
  input  logic [63:0] order_quantity,
  input  logic [63:0] price_cap,
  input  logic [63:0] report_session,
  input  logic [63:0] report_number,
  input  logic [2:0]  report_kind,
  input  logic [63:0] cum_quantity,
  input  logic [63:0] cum_cost,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic        order_found,
  output logic [3:0]  order_phase,
  output logic [63:0] order_filled,
  output logic [63:0] spent_total,
  output logic [63:0] reserved_total,
  output logic        halt_flag
);

  localparam int OCW = $clog2(ORDER_SLOTS + 1);
  localparam int OIW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int HCW = $clog2(HISTORY_SLOTS + 1);
  localparam int HIW = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;

  org_pkg::state_t  state, state_next;

  // Configuration and running totals
  logic [63:0] session_reg;
  logic [63:0] limit_reg;
  logic [OCW-1:0] slot_count;
  logic [HCW-1:0] seen_count;
  logic [63:0] spent_amt;
  logic [63:0] reserved_sum;
  logic        halted;

  // Captured input word
  logic [2:0]  action_r;
  logic [63:0] key_r, qty_r, price_r, sess_r, num_r, cq_r, cc_r;
  logic [2:0]  kind_r;

  // Working entry and flags
  org_pkg::slot_t   cur;
  logic [OIW-1:0]   cur_idx;
  logic             found_r;
  logic             wr_slot, wr_hist;
  org_pkg::status_t st_r;
  logic [63:0]      nq_r, nc_r, nres_r;
  org_pkg::phase_t  newph_r;
  logic             newcf_r;

  // Memories
  org_pkg::slot_t ord_mem [ORDER_SLOTS];
  org_pkg::hist_t hist_mem [HISTORY_SLOTS];
  org_pkg::slot_t ord_q;
  org_pkg::hist_t hist_q;
  logic [OCW-1:0] oscan_idx;
  logic [OIW-1:0] opend_idx;
  logic           opend;
  logic [HCW-1:0] hscan_idx;
  logic           hpend;

  // Multiplier
  org_pkg::mul_req_t mreq;
  logic              mul_done;
  logic [127:0]      mul_prod;

  org_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == org_pkg::S_IDLE);

  // Scan compares
  logic o_hit, o_miss, h_hit, h_miss, h_dup;
  assign o_hit  = opend && (ord_q.key == key_r);
  assign o_miss = !o_hit && (oscan_idx >= slot_count);
  assign h_hit  = hpend && (hist_q.order == key_r) && (hist_q.number == num_r);
  assign h_miss = !h_hit && (hscan_idx >= seen_count);
  assign h_dup  = (hist_q.session == sess_r) && (hist_q.kind == kind_r) &&
                  (hist_q.quantity == cq_r) && (hist_q.cost == cc_r);

  // Report checks after the fill product
  logic            term_ph;
  logic            rep_bad;
  org_pkg::phase_t ph_c;
  logic            cf_c;
  assign term_ph = org_pkg::is_terminal(cur.phase);
  assign rep_bad = (nc_r > mul_prod[63:0]) || ((nq_r != 64'd0) && (nc_r == 64'd0)) ||
                   (term_ph && (nq_r != 64'd0)) ||
                   ((kind_r == org_pkg::K_TRADE) && (nq_r == 64'd0)) ||
                   (((kind_r == org_pkg::K_CANACK) || (kind_r == org_pkg::K_CANREJ)) &&
                    !cur.cancel_flag) ||
                   ((kind_r == org_pkg::K_REJNEW) && ((cq_r != 64'd0) || term_ph));

  // Next phase of an accepted report
  always_comb begin
    ph_c = cur.phase;
    cf_c = cur.cancel_flag;
    if (!term_ph) begin
      if (kind_r == org_pkg::K_REJNEW) ph_c = org_pkg::PH_REJECTED;
      else if (cq_r == cur.quantity) ph_c = org_pkg::PH_FILLED;
      else if (kind_r == org_pkg::K_CANACK) ph_c = org_pkg::PH_CANCELED;
      else if (kind_r == org_pkg::K_CANREJ) begin
        cf_c = 1'b0;
        if (cur.phase != org_pkg::PH_UNKNOWN) ph_c = org_pkg::PH_LIVE;
      end else if (cur.phase == org_pkg::PH_PENDNEW) ph_c = org_pkg::PH_LIVE;
    end
  end

  // Final budget checks
  logic [63:0] remain_c, head_c;
  logic        fin_bad;
  assign remain_c = reserved_sum - cur.reserved + nres_r;
  assign head_c   = org_pkg::sat_sub(limit_reg, spent_amt);
  assign fin_bad  = (nc_r > cur.reserved) || (nres_r > cur.reserved - nc_r) ||
                    (nc_r > head_c) || (remain_c > head_c - nc_r);

  logic prep_bad;
  assign prep_bad = (key_r == 64'd0) || (qty_r == 64'd0) || (price_r == 64'd0) ||
                    (mul_prod[127:64] != 64'd0);

  logic rchk1_bad;
  assign rchk1_bad = (cur.phase == org_pkg::PH_PREPARED) ||
                     (cur.phase == org_pkg::PH_LOCALFAIL) || (cq_r < cur.filled) ||
                     (cq_r > cur.quantity) || (cc_r < cur.cost);

  // Multiplier requests
  always_comb begin
    mreq = '0;
    unique case (state)
      org_pkg::S_DECIDE: begin
        mreq.start = (action_r == org_pkg::ACT_PREPARE) && !halted;
        mreq.a     = qty_r;
        mreq.b     = price_r;
      end
      org_pkg::S_RCHK1: begin
        mreq.start = !(num_r < cur.last_num) &&
                     !(seen_count >= HCW'(HISTORY_SLOTS)) && !rchk1_bad;
        mreq.a     = cq_r - cur.filled;
        mreq.b     = cur.price;
      end
      org_pkg::S_RMUL1: begin
        mreq.start = mul_done && !rep_bad && !org_pkg::is_terminal(ph_c);
        mreq.a     = cur.quantity - cq_r;
        mreq.b     = cur.price;
      end
      default: mreq = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      org_pkg::S_IDLE:   if (in_valid) state_next = org_pkg::S_OSCAN;
      org_pkg::S_OSCAN:  if (o_hit || o_miss) state_next = org_pkg::S_DECIDE;
      org_pkg::S_DECIDE: begin
        if (mreq.start) state_next = org_pkg::S_PMUL;
        else if ((action_r == org_pkg::ACT_REPORT) && (sess_r == session_reg) && found_r &&
                 (num_r != 64'd0) && (kind_r <= org_pkg::K_REJNEW))
          state_next = org_pkg::S_HSCAN;
        else state_next = org_pkg::S_FIN;
      end
      org_pkg::S_PMUL:   if (mul_done) state_next = org_pkg::S_FIN;
      org_pkg::S_HSCAN: begin
        if (h_hit) state_next = org_pkg::S_FIN;
        else if (h_miss) state_next = org_pkg::S_RCHK1;
      end
      org_pkg::S_RCHK1:  state_next = mreq.start ? org_pkg::S_RMUL1 : org_pkg::S_FIN;
      org_pkg::S_RMUL1: begin
        if (mul_done) begin
          if (rep_bad) state_next = org_pkg::S_FIN;
          else if (mreq.start) state_next = org_pkg::S_RMUL2;
          else state_next = org_pkg::S_RCHK3;
        end
      end
      org_pkg::S_RMUL2:  if (mul_done) state_next = org_pkg::S_RCHK3;
      org_pkg::S_RCHK3:  state_next = org_pkg::S_FIN;
      org_pkg::S_FIN:    if (!out_valid || out_ready) state_next = org_pkg::S_IDLE;
      default:           state_next = org_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= org_pkg::S_IDLE;
    else state <= state_next;
  end

  // Memory reads, registered
  always_ff @(posedge clk) begin
    ord_q  <= ord_mem[oscan_idx[OIW-1:0]];
    hist_q <= hist_mem[hscan_idx[HIW-1:0]];
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if ((state == org_pkg::S_FIN) && (state_next == org_pkg::S_IDLE)) begin
      if (wr_slot) ord_mem[cur_idx] <= cur;
      if (wr_hist) hist_mem[seen_count[HIW-1:0] - HIW'(1)] <= '{order: key_r,
        number: num_r, kind: kind_r, quantity: cq_r, cost: cc_r, session: sess_r};
    end
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      session_reg <= 64'd1;
      limit_reg   <= 64'd0;
    end else if (cfg_valid) begin
      if (cfg_index == org_pkg::REG_SESSION) session_reg <= cfg_data;
      else if (cfg_index == org_pkg::REG_LIMIT) limit_reg <= cfg_data;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count   <= '0;
      seen_count   <= '0;
      spent_amt    <= 64'd0;
      reserved_sum <= 64'd0;
      halted       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != org_pkg::S_FIN)) out_valid <= 1'b0;
      case (state)
        org_pkg::S_IDLE: begin
          if (in_valid) begin
            action_r  <= action;
            key_r     <= order_key;
            qty_r     <= order_quantity;
            price_r   <= price_cap;
            sess_r    <= report_session;
            num_r     <= report_number;
            kind_r    <= report_kind;
            cq_r      <= cum_quantity;
            cc_r      <= cum_cost;
            oscan_idx <= '0;
            opend     <= 1'b0;
            found_r   <= 1'b0;
            wr_slot   <= 1'b0;
            wr_hist   <= 1'b0;
          end
        end
        org_pkg::S_OSCAN: begin
          if (o_hit) begin
            found_r <= 1'b1;
            cur     <= ord_q;
            cur_idx <= opend_idx;
          end
          if (oscan_idx < slot_count) begin
            opend     <= 1'b1;
            opend_idx <= oscan_idx[OIW-1:0];
            oscan_idx <= oscan_idx + OCW'(1);
          end else begin
            opend <= 1'b0;
          end
        end
        org_pkg::S_DECIDE: begin
          hscan_idx <= '0;
          hpend     <= 1'b0;
          case (action_r) inside
            org_pkg::ACT_PREPARE: st_r <= org_pkg::ST_HALTED;
            org_pkg::ACT_REPORT: begin
              if ((sess_r != session_reg) || !found_r) st_r <= org_pkg::ST_FOREIGN;
              else if ((num_r == 64'd0) || (kind_r > org_pkg::K_REJNEW)) begin
                st_r      <= org_pkg::ST_INVALID;
                halted    <= 1'b1;
                cur.phase <= org_pkg::halt_phase(cur.phase);
                wr_slot   <= 1'b1;
              end
            end
            org_pkg::ACT_FAIL, org_pkg::ACT_DISPATCH, org_pkg::ACT_UNCERTAIN,
            org_pkg::ACT_CANCEL: begin
              if (((action_r == org_pkg::ACT_DISPATCH) || (action_r == org_pkg::ACT_CANCEL))
                  && halted) begin
                st_r <= org_pkg::ST_HALTED;
              end else if (found_r && (action_r == org_pkg::ACT_FAIL) &&
                           (cur.phase == org_pkg::PH_PREPARED)) begin
                reserved_sum <= reserved_sum - cur.reserved;
                cur.reserved <= 64'd0;
                cur.phase    <= org_pkg::PH_LOCALFAIL;
                wr_slot      <= 1'b1;
                st_r         <= org_pkg::ST_OK;
              end else if (found_r && (action_r == org_pkg::ACT_DISPATCH) &&
                           (cur.phase == org_pkg::PH_PREPARED)) begin
                cur.phase <= org_pkg::PH_PENDNEW;
                wr_slot   <= 1'b1;
                st_r      <= org_pkg::ST_OK;
              end else if (found_r && (action_r == org_pkg::ACT_UNCERTAIN) &&
                           (cur.phase != org_pkg::PH_PREPARED) && !term_ph) begin
                cur.phase <= org_pkg::PH_UNKNOWN;
                wr_slot   <= 1'b1;
                st_r      <= org_pkg::ST_OK;
              end else if (found_r && (action_r == org_pkg::ACT_CANCEL) &&
                           ((cur.phase == org_pkg::PH_PENDNEW) ||
                            (cur.phase == org_pkg::PH_LIVE))) begin
                cur.cancel_flag <= 1'b1;
                cur.phase       <= org_pkg::PH_PENDCAN;
                wr_slot         <= 1'b1;
                st_r            <= org_pkg::ST_OK;
              end else begin
                st_r <= org_pkg::ST_BADSTATE;
              end
            end
            default: st_r <= org_pkg::ST_INVALID;
          endcase
        end
        org_pkg::S_PMUL: begin
          if (mul_done) begin
            if (prep_bad) st_r <= org_pkg::ST_INVALID;
            else if (found_r) st_r <= org_pkg::ST_CONFLICT;
            else if (slot_count >= OCW'(ORDER_SLOTS)) st_r <= org_pkg::ST_ORDERFULL;
            else if (mul_prod[63:0] > org_pkg::sat_sub(head_c, reserved_sum))
              st_r <= org_pkg::ST_RISK;
            else begin
              st_r    <= org_pkg::ST_OK;
              found_r <= 1'b1;
              cur     <= '{key: key_r, quantity: qty_r, price: price_r, filled: 64'd0,
                           cost: 64'd0, reserved: mul_prod[63:0], last_num: 64'd0,
                           cancel_flag: 1'b0, phase: org_pkg::PH_PREPARED};
              cur_idx      <= slot_count[OIW-1:0];
              slot_count   <= slot_count + OCW'(1);
              reserved_sum <= reserved_sum + mul_prod[63:0];
              wr_slot      <= 1'b1;
            end
          end
        end
        org_pkg::S_HSCAN: begin
          if (h_hit) begin
            if (h_dup) st_r <= org_pkg::ST_DUP;
            else begin
              st_r      <= org_pkg::ST_CONFLICT;
              halted    <= 1'b1;
              cur.phase <= org_pkg::halt_phase(cur.phase);
              wr_slot   <= 1'b1;
            end
          end
          if (hscan_idx < seen_count) begin
            hpend     <= 1'b1;
            hscan_idx <= hscan_idx + HCW'(1);
          end else begin
            hpend <= 1'b0;
          end
        end
        org_pkg::S_RCHK1: begin
          nq_r <= cq_r - cur.filled;
          nc_r <= cc_r - cur.cost;
          if (num_r < cur.last_num) st_r <= org_pkg::ST_STALE;
          else if (!mreq.start) begin
            st_r      <= (seen_count >= HCW'(HISTORY_SLOTS)) ? org_pkg::ST_REPORTFULL
                                                             : org_pkg::ST_INVALID;
            halted    <= 1'b1;
            cur.phase <= org_pkg::halt_phase(cur.phase);
            wr_slot   <= 1'b1;
          end
        end
        org_pkg::S_RMUL1: begin
          if (mul_done) begin
            newph_r <= ph_c;
            newcf_r <= cf_c;
            nres_r  <= 64'd0;
            if (rep_bad) begin
              st_r      <= org_pkg::ST_INVALID;
              halted    <= 1'b1;
              cur.phase <= org_pkg::halt_phase(cur.phase);
              wr_slot   <= 1'b1;
            end
          end
        end
        org_pkg::S_RMUL2: begin
          if (mul_done) nres_r <= mul_prod[63:0];
        end
        org_pkg::S_RCHK3: begin
          wr_slot <= 1'b1;
          if (fin_bad) begin
            st_r      <= org_pkg::ST_INVALID;
            halted    <= 1'b1;
            cur.phase <= org_pkg::halt_phase(cur.phase);
          end else begin
            st_r            <= org_pkg::ST_OK;
            spent_amt       <= spent_amt + nc_r;
            reserved_sum    <= remain_c;
            cur.filled      <= cq_r;
            cur.cost        <= cc_r;
            cur.last_num    <= num_r;
            cur.cancel_flag <= newcf_r;
            cur.phase       <= newph_r;
            cur.reserved    <= nres_r;
            seen_count      <= seen_count + HCW'(1);
            wr_hist         <= 1'b1;
          end
        end
        org_pkg::S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            status         <= st_r;
            order_found    <= found_r;
            order_phase    <= found_r ? cur.phase : 4'd0;
            order_filled   <= found_r ? cur.filled : 64'd0;
            spent_total    <= spent_amt;
            reserved_total <= reserved_sum;
            halt_flag      <= halted;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/org_checker.sv @@
`timescale 1ns / 1ps

module org_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  status,
  input logic        order_found,
  input logic [3:0]  order_phase,
  input logic [63:0] order_filled,
  input logic        halt_flag
);

  // A halted answer always comes with the latch set
  a_halt_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == org_pkg::ST_HALTED) |-> halt_flag)
    else $error("halted status without halt flag");

  // Missing orders report zero phase and fill
  a_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !order_found |-> (order_phase == 4'd0) && (order_filled == 64'd0))
    else $error("missing order with nonzero fields");

  // A duplicate can only be seen on a known order
  a_dup_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == org_pkg::ST_DUP) |-> order_found)
    else $error("duplicate on unknown order");

  // One word in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped before taken");

endmodule

bind order_risk_gate_core org_checker u_org_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .order_found  (order_found),
  .order_phase  (order_phase),
  .order_filled (order_filled),
  .halt_flag    (halt_flag)
);
